/* sv/mbt_pkg.sv */
`default_nettype none

package mbt_pkg;

    // Input word: one host command or one pattern element.
    typedef struct packed {
        logic [1:0]         opcode;
        logic               weight_layer;
        logic [8:0]         weight_index;
        logic signed [23:0] weight_value;
        logic [15:0]        element_value;
        logic [1:0]         target_class;
        logic               pattern_last;
    } in_word_t;

    // Result word: an output neuron report or weight read data.
    typedef struct packed {
        logic               result_kind;
        logic [1:0]         neuron_index;
        logic [15:0]        activation_out;
        logic signed [23:0] value_out;
        logic               last_result;
    } out_word_t;

    // Command codes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_ELEM  = 2'd2;

    // Layer select and result kinds.
    localparam logic LAYER_HIDDEN = 1'b0;
    localparam logic LAYER_OUTPUT = 1'b1;
    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_WEIGHT  = 1'b1;

    // Saturation limits for Q8.16 values.
    localparam logic signed [23:0] W_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] W_MIN = -24'sh800000;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_RD_WAIT, ST_RD_CAP,
        ST_F1_RD, ST_F1_MUL, ST_F1_ACC,
        ST_SIG_A, ST_SIG_B, ST_SIG_C,
        ST_F2_RD, ST_F2_MUL, ST_F2_ACC,
        ST_OD_A, ST_OD_B, ST_OD_C,
        ST_B_RD, ST_B_MUL, ST_B_ACC,
        ST_HD_A, ST_HD_B, ST_HD_C,
        ST_UO_L, ST_UO_RD, ST_UO_MUL, ST_UO_WR,
        ST_UH_I, ST_UH_L, ST_UH_RD, ST_UH_MUL, ST_UH_WR,
        ST_EMIT
    } state_t;

    // Saturate a wide signed value to 24 bits.
    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607) begin
            r = W_MAX;
        end else if (v < -64'sd8388608) begin
            r = W_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    // Sigmoid at k/2 for k = 0..16, unsigned Q0.16.
    function automatic logic [15:0] sig_tab(input logic [4:0] k);
        logic [15:0] r;
        case (k)
            5'd0:    r = 16'd32768;
            5'd1:    r = 16'd40793;
            5'd2:    r = 16'd47910;
            5'd3:    r = 16'd53581;
            5'd4:    r = 16'd57724;
            5'd5:    r = 16'd60565;
            5'd6:    r = 16'd62428;
            5'd7:    r = 16'd63615;
            5'd8:    r = 16'd64357;
            5'd9:    r = 16'd64816;
            5'd10:   r = 16'd65097;
            5'd11:   r = 16'd65269;
            5'd12:   r = 16'd65374;
            5'd13:   r = 16'd65438;
            5'd14:   r = 16'd65476;
            5'd15:   r = 16'd65500;
            default: r = 16'd65514;
        endcase
        return r;
    endfunction

    // Step to the next table entry; zero at and beyond the last one.
    function automatic logic [13:0] sig_diff(input logic [4:0] k);
        logic [13:0] r;
        if (k >= 5'd16) begin
            r = '0;
        end else begin
            r = 14'(sig_tab(k + 5'd1) - sig_tab(k));
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/mlp_backprop_trainer.sv */
`default_nettype none

// Channel   Direction  Ports                         Word
// input     in         s_valid, s_ready, s_data      in_word_t
// result    out        m_valid, m_ready, m_data      out_word_t
// config    in         cfg_wr_en, cfg_wr_data        learning rate, Q4.12
//
// A weight write, an element without the last mark, or an unused opcode is
// handled in the idle state without leaving it; a weight read passes through
// ST_RD_WAIT and ST_RD_CAP before its result word is shown. A training step
// runs on one shared multiplier: hidden sums, output sums and deltas, back sums
// and hidden deltas, output and hidden weight updates; then the O report words
// are shown one per accepted cycle. After reset a clearing pass zeroes both
// weight memories; no input word is taken meanwhile. Input is taken only while idle.

module mlp_backprop_trainer
    import mbt_pkg::*;
#(
    parameter int INPUT_COUNT  = 35,
    parameter int HIDDEN_COUNT = 8,
    parameter int OUTPUT_COUNT = 4
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data,
    input  wire logic      cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    localparam int HWD = HIDDEN_COUNT * INPUT_COUNT;
    localparam int OWD = OUTPUT_COUNT * HIDDEN_COUNT;
    localparam int CLR_DEPTH = (HWD > OWD) ? HWD : OWD;
    localparam int IW  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
    localparam int ECW = $clog2(INPUT_COUNT + 1);
    localparam int HIW = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
    localparam int OIW = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
    localparam int HAW = (HWD > 1) ? $clog2(HWD) : 1;
    localparam int OAW = (OWD > 1) ? $clog2(OWD) : 1;
    localparam int CAW = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    state_t state_reg, state_next;
    logic [15:0] lr_reg;
    logic [ECW-1:0] elem_count_reg, elem_count_next;
    logic [IW-1:0] i_reg, i_next;
    logic [HIW-1:0] h_reg, h_next;
    logic [OIW-1:0] o_reg, o_next;
    logic [HAW-1:0] hw_addr_reg, hw_addr_next;
    logic [OAW-1:0] ow_addr_reg, ow_addr_next;
    logic [CAW-1:0] clr_reg, clr_next;
    logic signed [50:0] acc_reg, acc_next;
    logic signed [58:0] prod_reg;
    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic [4:0] sig_seg_reg, sig_seg_next;
    logic [14:0] sig_frac_reg, sig_frac_next;
    logic sig_neg_reg, sig_neg_next;
    logic sig_out_reg, sig_out_next;
    logic signed [17:0] tmina_reg, tmina_next;
    logic signed [33:0] back_reg, back_next;
    logic [31:0] c_reg, c_next;
    logic [1:0] target_reg, target_next;
    logic rd_ok_reg, rd_ok_next;
    logic rd_layer_reg, rd_layer_next;
    logic m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    // Per-neuron values of the current step.
    logic [15:0]        ha_reg [HIDDEN_COUNT];
    logic signed [23:0] hd_reg [HIDDEN_COUNT];
    logic [15:0]        oa_reg [OUTPUT_COUNT];
    logic signed [23:0] od_reg [OUTPUT_COUNT];
    logic ha_we, hd_we, oa_we, od_we;

    // Memory ports.
    logic hw_we, ow_we, ia_we;
    logic [HAW-1:0] hw_wa;
    logic [OAW-1:0] ow_wa;
    logic [IW-1:0] ia_wa;
    logic [23:0] hw_wd, ow_wd, hw_rdata, ow_rdata;
    logic [15:0] ia_rdata;

    // Helper values.
    logic hw_in_range, ow_in_range, ia_valid;
    logic [15:0] ia_gated;
    logic signed [23:0] sig_x;
    logic [23:0] sig_mag;
    logic [19:0] sig_m;
    logic [16:0] act_y;
    logic [15:0] act_val;
    logic signed [23:0] hd_val, od_val, ow_upd, hw_upd;
    logic [15:0] ha_cur, oa_cur;
    logic signed [23:0] od_cur, hd_cur;

    mbt_ram #(.WIDTH(24), .DEPTH(HWD)) u_hw_ram (
        .aclk(aclk), .wr_en(hw_we), .wr_addr(hw_wa), .wr_data(hw_wd),
        .rd_addr(hw_addr_reg), .rd_data(hw_rdata)
    );

    mbt_ram #(.WIDTH(24), .DEPTH(OWD)) u_ow_ram (
        .aclk(aclk), .wr_en(ow_we), .wr_addr(ow_wa), .wr_data(ow_wd),
        .rd_addr(ow_addr_reg), .rd_data(ow_rdata)
    );

    mbt_ram #(.WIDTH(16), .DEPTH(INPUT_COUNT)) u_ia_ram (
        .aclk(aclk), .wr_en(ia_we), .wr_addr(ia_wa), .wr_data(s_data.element_value),
        .rd_addr(i_reg), .rd_data(ia_rdata)
    );

    // Report word for one output neuron.
    function automatic out_word_t report(input logic [OIW-1:0] k);
        out_word_t r;
        r.result_kind    = KIND_REPORT;
        r.neuron_index   = 2'(k);
        r.activation_out = oa_reg[k];
        r.value_out      = od_reg[k];
        r.last_result    = (k == OIW'(OUTPUT_COUNT - 1));
        return r;
    endfunction

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Shared values feeding the sequencer.
    always_comb begin
        hw_in_range = ({1'b0, s_data.weight_index} < 10'(HWD));
        ow_in_range = ({1'b0, s_data.weight_index} < 10'(OWD));
        ia_valid    = (ECW'(i_reg) < elem_count_reg);
        ia_gated    = ia_valid ? ia_rdata : 16'd0;
        ha_cur      = ha_reg[h_reg];
        hd_cur      = hd_reg[h_reg];
        oa_cur      = oa_reg[o_reg];
        od_cur      = od_reg[o_reg];

        // Sigmoid: clamp the net sum, split into segment and fraction.
        sig_x   = sat24(64'(acc_reg >>> 16));
        sig_mag = sig_x[23] ? 24'(-sig_x) : 24'(sig_x);
        sig_m   = (sig_mag > 24'd524288) ? 20'd524288 : sig_mag[19:0];
        act_y   = 17'(sig_tab(sig_seg_reg)) + 17'(prod_reg[27:15]);
        act_val = sig_neg_reg ? 16'(17'd65536 - act_y) : act_y[15:0];

        hd_val = sat24(64'(prod_reg >>> 16));
        od_val = sat24(64'(prod_reg >>> 32));
        ow_upd = sat24(64'($signed(ow_rdata)) + 64'(prod_reg >>> 28));
        hw_upd = sat24(64'($signed(hw_rdata)) + 64'(prod_reg >>> 28));
    end

    // Sequencer: next state, operand selection and memory control.
    always_comb begin
        state_next      = state_reg;
        elem_count_next = elem_count_reg;
        i_next          = i_reg;
        h_next          = h_reg;
        o_next          = o_reg;
        hw_addr_next    = hw_addr_reg;
        ow_addr_next    = ow_addr_reg;
        clr_next        = clr_reg;
        acc_next        = acc_reg;
        sig_seg_next    = sig_seg_reg;
        sig_frac_next   = sig_frac_reg;
        sig_neg_next    = sig_neg_reg;
        sig_out_next    = sig_out_reg;
        tmina_next      = tmina_reg;
        back_next       = back_reg;
        c_next          = c_reg;
        target_next     = target_reg;
        rd_ok_next      = rd_ok_reg;
        rd_layer_next   = rd_layer_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        mul_a = '0;
        mul_b = '0;
        hw_we = 1'b0;
        hw_wa = hw_addr_reg;
        hw_wd = '0;
        ow_we = 1'b0;
        ow_wa = ow_addr_reg;
        ow_wd = '0;
        ia_we = 1'b0;
        ia_wa = elem_count_reg[IW-1:0];
        ha_we = 1'b0;
        hd_we = 1'b0;
        oa_we = 1'b0;
        od_we = 1'b0;

        case (state_reg)
            // Zero both weight memories, one entry a cycle.
            ST_CLEAR: begin
                hw_we = (32'(clr_reg) < HWD);
                hw_wa = HAW'(clr_reg);
                ow_we = (32'(clr_reg) < OWD);
                ow_wa = OAW'(clr_reg);
                if (clr_reg == CAW'(CLR_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + CAW'(1);
                end
            end

            // Take one input word.
            ST_IDLE: begin
                if (s_valid) begin
                    target_next = s_data.target_class;
                    case (s_data.opcode)
                        OP_WRITE: begin
                            hw_wa = HAW'(s_data.weight_index);
                            hw_wd = s_data.weight_value;
                            ow_wa = OAW'(s_data.weight_index);
                            ow_wd = s_data.weight_value;
                            hw_we = (s_data.weight_layer == LAYER_HIDDEN) && hw_in_range;
                            ow_we = (s_data.weight_layer == LAYER_OUTPUT) && ow_in_range;
                        end
                        OP_READ: begin
                            rd_layer_next = s_data.weight_layer;
                            rd_ok_next    = (s_data.weight_layer == LAYER_OUTPUT) ?
                                            ow_in_range : hw_in_range;
                            hw_addr_next  = HAW'(s_data.weight_index);
                            ow_addr_next  = OAW'(s_data.weight_index);
                            state_next    = ST_RD_WAIT;
                        end
                        OP_ELEM: begin
                            if (elem_count_reg < ECW'(INPUT_COUNT)) begin
                                ia_we           = 1'b1;
                                elem_count_next = elem_count_reg + ECW'(1);
                            end
                            if (s_data.pattern_last) begin
                                i_next       = '0;
                                h_next       = '0;
                                hw_addr_next = '0;
                                acc_next     = '0;
                                state_next   = ST_F1_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Host weight read.
            ST_RD_WAIT: begin
                state_next = ST_RD_CAP;
            end

            ST_RD_CAP: begin
                m_data_next.result_kind    = KIND_WEIGHT;
                m_data_next.neuron_index   = '0;
                m_data_next.activation_out = '0;
                m_data_next.value_out      = !rd_ok_reg ? 24'sd0 :
                                             (rd_layer_reg == LAYER_OUTPUT) ?
                                             $signed(ow_rdata) : $signed(hw_rdata);
                m_data_next.last_result    = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_EMIT;
            end

            // Hidden net sums.
            ST_F1_RD: begin
                state_next = ST_F1_MUL;
            end

            ST_F1_MUL: begin
                mul_a = {18'b0, ia_gated};
                mul_b = {hw_rdata[23], hw_rdata};
                state_next = ST_F1_ACC;
            end

            ST_F1_ACC: begin
                acc_next     = acc_reg + $signed(prod_reg[50:0]);
                hw_addr_next = hw_addr_reg + HAW'(1);
                if (i_reg == IW'(INPUT_COUNT - 1)) begin
                    sig_out_next = 1'b0;
                    state_next   = ST_SIG_A;
                end else begin
                    i_next     = i_reg + IW'(1);
                    state_next = ST_F1_RD;
                end
            end

            // Sigmoid by table and linear interpolation.
            ST_SIG_A: begin
                sig_neg_next  = sig_x[23];
                sig_seg_next  = sig_m[19:15];
                sig_frac_next = sig_m[14:0];
                state_next    = ST_SIG_B;
            end

            ST_SIG_B: begin
                mul_a = {19'b0, sig_frac_reg};
                mul_b = {11'b0, sig_diff(sig_seg_reg)};
                state_next = ST_SIG_C;
            end

            ST_SIG_C: begin
                acc_next = '0;
                if (!sig_out_reg) begin
                    ha_we = 1'b1;
                    if (h_reg == HIW'(HIDDEN_COUNT - 1)) begin
                        h_next       = '0;
                        o_next       = '0;
                        ow_addr_next = '0;
                        state_next   = ST_F2_RD;
                    end else begin
                        h_next     = h_reg + HIW'(1);
                        i_next     = '0;
                        state_next = ST_F1_RD;
                    end
                end else begin
                    oa_we      = 1'b1;
                    state_next = ST_OD_A;
                end
            end

            // Output net sums.
            ST_F2_RD: begin
                state_next = ST_F2_MUL;
            end

            ST_F2_MUL: begin
                mul_a = {18'b0, ha_cur};
                mul_b = {ow_rdata[23], ow_rdata};
                state_next = ST_F2_ACC;
            end

            ST_F2_ACC: begin
                acc_next     = acc_reg + $signed(prod_reg[50:0]);
                ow_addr_next = ow_addr_reg + OAW'(1);
                if (h_reg == HIW'(HIDDEN_COUNT - 1)) begin
                    h_next       = '0;
                    sig_out_next = 1'b1;
                    state_next   = ST_SIG_A;
                end else begin
                    h_next     = h_reg + HIW'(1);
                    state_next = ST_F2_RD;
                end
            end

            // Output delta a(1-a)(t-a).
            ST_OD_A: begin
                mul_a = {18'b0, oa_cur};
                mul_b = {8'b0, 17'(17'd65536 - {1'b0, oa_cur})};
                tmina_next = (OIW'(target_reg) == o_reg && {1'b0, target_reg} <
                             3'(OUTPUT_COUNT)) ? (18'sd65536 - $signed({2'b0, oa_cur}))
                             : (18'sd0 - $signed({2'b0, oa_cur}));
                state_next = ST_OD_B;
            end

            ST_OD_B: begin
                mul_a = prod_reg[33:0];
                mul_b = {{7{tmina_reg[17]}}, tmina_reg};
                state_next = ST_OD_C;
            end

            ST_OD_C: begin
                od_we = 1'b1;
                if (o_reg == OIW'(OUTPUT_COUNT - 1)) begin
                    o_next       = '0;
                    h_next       = '0;
                    ow_addr_next = '0;
                    state_next   = ST_B_RD;
                end else begin
                    o_next     = o_reg + OIW'(1);
                    state_next = ST_F2_RD;
                end
            end

            // Back-propagated sums through the old output weights.
            ST_B_RD: begin
                state_next = ST_B_MUL;
            end

            ST_B_MUL: begin
                mul_a = {{10{od_cur[23]}}, od_cur};
                mul_b = {ow_rdata[23], ow_rdata};
                state_next = ST_B_ACC;
            end

            ST_B_ACC: begin
                acc_next = acc_reg + $signed(prod_reg[50:0]);
                if (o_reg == OIW'(OUTPUT_COUNT - 1)) begin
                    state_next = ST_HD_A;
                end else begin
                    o_next       = o_reg + OIW'(1);
                    ow_addr_next = ow_addr_reg + OAW'(HIDDEN_COUNT);
                    state_next   = ST_B_RD;
                end
            end

            // Hidden delta: back sum times a(1-a).
            ST_HD_A: begin
                back_next = $signed(acc_reg[49:16]);
                acc_next  = '0;
                mul_a = {18'b0, ha_cur};
                mul_b = {8'b0, 17'(17'd65536 - {1'b0, ha_cur})};
                state_next = ST_HD_B;
            end

            ST_HD_B: begin
                mul_a = back_reg;
                mul_b = {10'b0, prod_reg[30:16]};
                state_next = ST_HD_C;
            end

            ST_HD_C: begin
                hd_we  = 1'b1;
                o_next = '0;
                if (h_reg == HIW'(HIDDEN_COUNT - 1)) begin
                    h_next       = '0;
                    ow_addr_next = '0;
                    state_next   = ST_UO_L;
                end else begin
                    h_next       = h_reg + HIW'(1);
                    ow_addr_next = OAW'(h_reg) + OAW'(1);
                    state_next   = ST_B_RD;
                end
            end

            // Output weight update, hidden neuron outer, output inner.
            ST_UO_L: begin
                mul_a = {18'b0, lr_reg};
                mul_b = {9'b0, ha_cur};
                state_next = ST_UO_RD;
            end

            ST_UO_RD: begin
                if (o_reg == '0) begin
                    c_next = prod_reg[31:0];
                end
                state_next = ST_UO_MUL;
            end

            ST_UO_MUL: begin
                mul_a = {2'b0, c_reg};
                mul_b = {od_cur[23], od_cur};
                state_next = ST_UO_WR;
            end

            ST_UO_WR: begin
                ow_we = 1'b1;
                ow_wd = ow_upd;
                if (o_reg == OIW'(OUTPUT_COUNT - 1)) begin
                    o_next = '0;
                    if (h_reg == HIW'(HIDDEN_COUNT - 1)) begin
                        h_next       = '0;
                        i_next       = '0;
                        hw_addr_next = '0;
                        state_next   = ST_UH_I;
                    end else begin
                        h_next       = h_reg + HIW'(1);
                        ow_addr_next = OAW'(h_reg) + OAW'(1);
                        state_next   = ST_UO_L;
                    end
                end else begin
                    o_next       = o_reg + OIW'(1);
                    ow_addr_next = ow_addr_reg + OAW'(HIDDEN_COUNT);
                    state_next   = ST_UO_RD;
                end
            end

            // Hidden weight update, input outer, hidden neuron inner.
            ST_UH_I: begin
                state_next = ST_UH_L;
            end

            ST_UH_L: begin
                mul_a = {18'b0, lr_reg};
                mul_b = {9'b0, ia_gated};
                state_next = ST_UH_RD;
            end

            ST_UH_RD: begin
                if (h_reg == '0) begin
                    c_next = prod_reg[31:0];
                end
                state_next = ST_UH_MUL;
            end

            ST_UH_MUL: begin
                mul_a = {2'b0, c_reg};
                mul_b = {hd_cur[23], hd_cur};
                state_next = ST_UH_WR;
            end

            ST_UH_WR: begin
                hw_we = 1'b1;
                hw_wd = hw_upd;
                if (h_reg == HIW'(HIDDEN_COUNT - 1)) begin
                    h_next = '0;
                    if (i_reg == IW'(INPUT_COUNT - 1)) begin
                        // Step done: clear the pattern and start the reports.
                        elem_count_next = '0;
                        o_next          = '0;
                        m_data_next     = report('0);
                        m_valid_next    = 1'b1;
                        state_next      = ST_EMIT;
                    end else begin
                        i_next       = i_reg + IW'(1);
                        hw_addr_next = HAW'(i_reg) + HAW'(1);
                        state_next   = ST_UH_I;
                    end
                end else begin
                    h_next       = h_reg + HIW'(1);
                    hw_addr_next = hw_addr_reg + HAW'(INPUT_COUNT);
                    state_next   = ST_UH_RD;
                end
            end

            // Show result words until the last one is taken.
            ST_EMIT: begin
                if (m_ready) begin
                    if (m_data_reg.last_result) begin
                        m_valid_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        o_next      = o_reg + OIW'(1);
                        m_data_next = report(o_reg + OIW'(1));
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            elem_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            elem_count_reg <= elem_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Learning rate register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg <= 16'd4096;
        end else if (cfg_wr_en) begin
            lr_reg <= cfg_wr_data;
        end
    end

    // Datapath registers and the shared multiplier.
    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        h_reg        <= h_next;
        o_reg        <= o_next;
        hw_addr_reg  <= hw_addr_next;
        ow_addr_reg  <= ow_addr_next;
        acc_reg      <= acc_next;
        prod_reg     <= 59'(mul_a * mul_b);
        sig_seg_reg  <= sig_seg_next;
        sig_frac_reg <= sig_frac_next;
        sig_neg_reg  <= sig_neg_next;
        sig_out_reg  <= sig_out_next;
        tmina_reg    <= tmina_next;
        back_reg     <= back_next;
        c_reg        <= c_next;
        target_reg   <= target_next;
        rd_ok_reg    <= rd_ok_next;
        rd_layer_reg <= rd_layer_next;
        m_data_reg   <= m_data_next;
        if (ha_we) begin
            ha_reg[h_reg] <= act_val;
        end
        if (hd_we) begin
            hd_reg[h_reg] <= hd_val;
        end
        if (oa_we) begin
            oa_reg[o_reg] <= act_val;
        end
        if (od_we) begin
            od_reg[o_reg] <= od_val;
        end
    end

endmodule

`default_nettype wire

/* sv/mbt_ram.sv */
`default_nettype none

module mbt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

/* tb/tb_mlp_backprop_trainer.sv */
`default_nettype none

module tb_mlp_backprop_trainer;
    import mbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_IN   = 35;
    localparam int N_HID  = 8;
    localparam int N_OUT  = 4;
    localparam int STALL_LIMIT = 20000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;
    logic      cfg_wr_en;
    logic [15:0] cfg_wr_data;

    mlp_backprop_trainer #(
        .INPUT_COUNT(N_IN),
        .HIDDEN_COUNT(N_HID),
        .OUTPUT_COUNT(N_OUT)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Predictor state: a private copy of the network and the rate.
    logic [15:0]        rate_q412;
    logic signed [23:0] w_hid [N_HID*N_IN] = '{default: '0};
    logic signed [23:0] w_out [N_OUT*N_HID] = '{default: '0};
    logic [15:0]        x_in [N_IN] = '{default: '0};
    logic [15:0]        a_hid [N_HID];
    logic signed [23:0] d_hid [N_HID];
    logic signed [23:0] d_out [N_OUT];
    int                 n_elems = 0;

    in_word_t  cmd_queue [$];
    out_word_t report_queue [$];

    int  errors = 0;
    int  accepted_in = 0;
    int  accepted_out = 0;
    int  idle_in_pct;
    int  idle_out_pct;
    bit  hold_off;
    int  quiet_cycles = 0;
    bit  done;

    localparam int SIG_POINTS [17] = '{32768, 40793, 47910, 53581, 57724, 60565, 62428,
        63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};

    function automatic longint floor_rshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint squash_pos(longint m);
        longint seg;
        longint frac;
        if (m > 524288) m = 524288;
        seg = m >> 15;
        frac = m & 32767;
        if (seg >= 16) return SIG_POINTS[16];
        return SIG_POINTS[seg] + (((SIG_POINTS[seg+1] - SIG_POINTS[seg]) * frac) >>> 15);
    endfunction

    function automatic longint squash(longint x);
        if (x >= 0) return squash_pos(x);
        return 65536 - squash_pos(-x);
    endfunction

    // One training step: forward pass, deltas, updates, then the reports.
    task automatic train_step(input logic [1:0] target);
        longint    acc;
        longint    a;
        longint    t;
        longint    back;
        longint    sq;
        longint    p;
        longint    o_act [N_OUT];
        out_word_t r;
        for (int h = 0; h < N_HID; h++) begin
            acc = 0;
            for (int i = 0; i < N_IN; i++)
                acc += longint'(x_in[i]) * longint'(w_hid[h*N_IN+i]);
            a_hid[h] = 16'(squash(clip24(floor_rshift(acc, 16))));
        end
        for (int o = 0; o < N_OUT; o++) begin
            acc = 0;
            for (int h = 0; h < N_HID; h++)
                acc += longint'(a_hid[h]) * longint'(w_out[o*N_HID+h]);
            o_act[o] = squash(clip24(floor_rshift(acc, 16)));
            a = o_act[o];
            t = (o == int'(target)) ? 65536 : 0;
            d_out[o] = 24'(clip24(floor_rshift(a * (65536 - a) * (t - a), 32)));
        end
        // Hidden deltas use the weights from before the update.
        for (int h = 0; h < N_HID; h++) begin
            acc = 0;
            for (int o = 0; o < N_OUT; o++)
                acc += longint'(d_out[o]) * longint'(w_out[o*N_HID+h]);
            back = floor_rshift(acc, 16);
            a = a_hid[h];
            sq = floor_rshift(a * (65536 - a), 16);
            d_hid[h] = 24'(clip24(floor_rshift(back * sq, 16)));
        end
        for (int o = 0; o < N_OUT; o++)
            for (int h = 0; h < N_HID; h++) begin
                p = longint'(rate_q412) * longint'(d_out[o]) * longint'(a_hid[h]);
                w_out[o*N_HID+h] = 24'(clip24(longint'(w_out[o*N_HID+h])
                                              + floor_rshift(p, 28)));
            end
        for (int h = 0; h < N_HID; h++)
            for (int i = 0; i < N_IN; i++) begin
                p = longint'(rate_q412) * longint'(d_hid[h]) * longint'(x_in[i]);
                w_hid[h*N_IN+i] = 24'(clip24(longint'(w_hid[h*N_IN+i])
                                             + floor_rshift(p, 28)));
            end
        for (int o = 0; o < N_OUT; o++) begin
            r.result_kind    = KIND_REPORT;
            r.neuron_index   = 2'(o);
            r.activation_out = 16'(o_act[o]);
            r.value_out      = d_out[o];
            r.last_result    = (o == N_OUT - 1);
            report_queue.push_back(r);
        end
        for (int i = 0; i < N_IN; i++) x_in[i] = '0;
        n_elems = 0;
    endtask

    // Apply one accepted word to the predictor.
    task automatic predict_word(input in_word_t w);
        bit        hit;
        out_word_t r;
        if (w.weight_layer == LAYER_HIDDEN) hit = (w.weight_index < N_HID*N_IN);
        else hit = (w.weight_index < N_OUT*N_HID);
        case (w.opcode)
            OP_WRITE: begin
                if (hit) begin
                    if (w.weight_layer == LAYER_HIDDEN) w_hid[w.weight_index] = w.weight_value;
                    else w_out[w.weight_index] = w.weight_value;
                end
            end
            OP_READ: begin
                r = '0;
                r.result_kind = KIND_WEIGHT;
                r.last_result = 1'b1;
                if (hit) r.value_out = (w.weight_layer == LAYER_HIDDEN) ?
                    w_hid[w.weight_index] : w_out[w.weight_index];
                report_queue.push_back(r);
            end
            OP_ELEM: begin
                if (n_elems < N_IN) begin
                    x_in[n_elems] = w.element_value;
                    n_elems++;
                end
                if (w.pattern_last) train_step(w.target_class);
            end
            default: ;
        endcase
    endtask

    // Clock.
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Driver: offers queued words, idling at random between them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid && s_ready) begin
                predict_word(s_data);
                accepted_in++;
            end
            if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_in_pct) begin
                s_valid <= 1'b1;
                s_data  <= cmd_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result word against the oldest expected one.
    always @(posedge aclk) begin
        out_word_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                accepted_out++;
                if (report_queue.size() == 0) begin
                    $error("unexpected result word %h", m_data);
                    errors++;
                end else begin
                    e = report_queue.pop_front();
                    if (m_data.result_kind !== e.result_kind) begin
                        $error("result_kind exp %0d got %0d", e.result_kind,
                               m_data.result_kind);
                        errors++;
                    end
                    if (m_data.neuron_index !== e.neuron_index) begin
                        $error("neuron_index exp %0d got %0d", e.neuron_index,
                               m_data.neuron_index);
                        errors++;
                    end
                    if (m_data.activation_out !== e.activation_out) begin
                        $error("activation_out exp %0d got %0d", e.activation_out,
                               m_data.activation_out);
                        errors++;
                    end
                    if (m_data.value_out !== e.value_out) begin
                        $error("value_out exp %0d got %0d", e.value_out, m_data.value_out);
                        errors++;
                    end
                    if (m_data.last_result !== e.last_result) begin
                        $error("last_result exp %0d got %0d", e.last_result,
                               m_data.last_result);
                        errors++;
                    end
                end
            end
            m_ready <= !hold_off && ($urandom_range(99) >= idle_out_pct);
        end
    end

    // Watchdog on cycles with no accepted word on either side.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (!done) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic in_word_t make_write(logic layer, logic [8:0] idx, logic [23:0] v);
        in_word_t w;
        w = '0;
        w.opcode = OP_WRITE;
        w.weight_layer = layer;
        w.weight_index = idx;
        w.weight_value = v;
        return w;
    endfunction

    function automatic in_word_t make_read(logic layer, logic [8:0] idx);
        in_word_t w;
        w = '0;
        w.opcode = OP_READ;
        w.weight_layer = layer;
        w.weight_index = idx;
        return w;
    endfunction

    function automatic in_word_t make_elem(logic [15:0] v, logic [1:0] tgt, logic last);
        in_word_t w;
        w = '0;
        w.opcode = OP_ELEM;
        w.element_value = v;
        w.target_class = tgt;
        w.pattern_last = last;
        w.weight_index = 9'($urandom);
        w.weight_value = 24'($urandom);
        return w;
    endfunction

    // Queue a pattern of the given length, with random content.
    task automatic queue_pattern(int len);
        for (int k = 0; k < len; k++)
            cmd_queue.push_back(make_elem(16'($urandom), 2'($urandom), k == len - 1));
    endtask

    // Queue one random word: mostly small weights and whole patterns.
    task automatic queue_random_word();
        int       pick;
        in_word_t w;
        pick = $urandom_range(99);
        if (pick < 30) begin
            w = make_write(1'($urandom), 9'($urandom_range(300)), 24'($urandom));
            if ($urandom_range(3) != 0) w.weight_value = 24'($signed($urandom_range(131071)) - 65536);
            cmd_queue.push_back(w);
        end else if (pick < 50) begin
            cmd_queue.push_back(make_read(1'($urandom), 9'($urandom)));
        end else if (pick < 54) begin
            w = '0;
            w.opcode = 2'd3;
            w.weight_value = 24'($urandom);
            cmd_queue.push_back(w);
        end else begin
            queue_pattern($urandom_range(1, 8) == 1 ? $urandom_range(30, 40)
                                                   : $urandom_range(1, 10));
        end
    endtask

    task automatic wait_drained(int settle);
        while (cmd_queue.size() > 0 || s_valid || report_queue.size() > 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic set_rate(logic [15:0] r);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        rate_q412 = r;
    endtask

    // Stimulus and phases.
    initial begin
        logic [15:0] rates [4];
        rates = '{16'd0, 16'd65535, 16'd4096, 16'd1024};
        idle_in_pct = 34;
        idle_out_pct = 55;
        hold_off = 1'b0;
        done = 1'b0;
        rate_q412 = 16'd4096;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words: extremes, every opcode, out-of-range indexes, odd targets.
        cmd_queue.push_back(make_read(LAYER_HIDDEN, 9'd0));
        cmd_queue.push_back(make_write(LAYER_HIDDEN, 9'd0, 24'h7FFFFF));
        cmd_queue.push_back(make_write(LAYER_HIDDEN, 9'd279, 24'h800000));
        cmd_queue.push_back(make_write(LAYER_HIDDEN, 9'd280, 24'h123456));
        cmd_queue.push_back(make_write(LAYER_OUTPUT, 9'd31, 24'h00FFFF));
        cmd_queue.push_back(make_write(LAYER_OUTPUT, 9'd32, 24'h0ABCDE));
        cmd_queue.push_back(make_write(LAYER_OUTPUT, 9'd0, 24'hFF0000));
        cmd_queue.push_back(make_read(LAYER_HIDDEN, 9'd279));
        cmd_queue.push_back(make_read(LAYER_HIDDEN, 9'd280));
        cmd_queue.push_back(make_read(LAYER_OUTPUT, 9'd31));
        cmd_queue.push_back(make_read(LAYER_OUTPUT, 9'd511));
        begin
            in_word_t w;
            w = '1;
            cmd_queue.push_back(w);
        end
        cmd_queue.push_back(make_elem(16'hFFFF, 2'd0, 1'b0));
        cmd_queue.push_back(make_elem(16'h0000, 2'd3, 1'b1));
        cmd_queue.push_back(make_elem(16'h8000, 2'd1, 1'b1));
        for (int k = 0; k < 37; k++)
            cmd_queue.push_back(make_elem(16'hFFFF, 2'd2, k == 36));
        cmd_queue.push_back(make_read(LAYER_HIDDEN, 9'd0));
        cmd_queue.push_back(make_read(LAYER_OUTPUT, 9'd0));
        wait_drained(40);

        // Random phases, each at its own learning rate and a chosen idling mix.
        for (int ph = 0; ph < 4; ph++) begin
            set_rate(rates[ph]);
            if (ph == 1) begin
                idle_in_pct = 55;
                idle_out_pct = 34;
            end else if (ph >= 2) begin
                idle_in_pct = 0;
                idle_out_pct = 0;
            end
            if (ph == 3) begin
                // Reads go first so that a result word is waiting during the hold.
                for (int k = 0; k < 6; k++) cmd_queue.push_back(make_read(1'($urandom), 9'($urandom)));
            end
            for (int k = 0; k < 8; k++) queue_random_word();
            if (ph == 3) begin
                // Hold the receiver off while words keep arriving.
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            wait_drained(40);
        end

        done = 1'b1;
        $display("Covered %0d input words and %0d result words over four learning rates,",
                 accepted_in, accepted_out);
        $display("with weight access, patterns of varied length, and stalls on both sides.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/mbt_pkg.sv
sv/mbt_ram.sv
sv/mlp_backprop_trainer.sv
tb/tb_mlp_backprop_trainer.sv
